[rtl/sbq_pkg.sv]
package sbq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = SAMPLE_W + WORD_W;
    localparam int ACC_W      = 60;
    localparam int FRAC_SHIFT = 22;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [Q_W-1:0]      t_q;

    localparam t_acc    ROUND_HALF = t_acc'(1) <<< (FRAC_SHIFT - 1);
    localparam t_word   WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word   WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_BYPASS = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        MS_A1W1,
        MS_A2W2,
        MS_B1W1,
        MS_B2W2,
        MS_B0W
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SUB,
        ACC_ADD,
        ACC_LOAD_P
    } t_acc_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_M1,
        S_M2,
        S_M3,
        S_W,
        S_M4,
        S_M5,
        S_Y
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     rd_en;
        logic     rd_word;
        logic     ld_w1;
        logic     ld_w2;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     fin_w;
        logic     wr_en;
        logic     wr_word;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic bypass;
    } t_status;

endpackage

[rtl/sbq_in_if.sv]
interface sbq_in_if import sbq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    logic    channel;

    modport source (output valid, output sample_in, output channel, input ready);
    modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

[rtl/sbq_out_if.sv]
interface sbq_out_if import sbq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample filtered_sample;
    logic    clipped;

    modport source (output valid, output filtered_sample, output clipped, input ready);
    modport sink   (input valid, input filtered_sample, input clipped, output ready);
endinterface

[rtl/stereo_biquad_df2_filter.sv]
// Stereo direct form II biquad. Each input transaction carries a Q1.23 sample and a
// channel select; each yields one output transaction with the saturated Q1.23 result
// and a clip flag. One shared 24x32 multiplier and a 60-bit accumulator run five
// multiply-accumulate steps per sample before a filtered sample is loaded into the output
// register; the load waits while an earlier result is unread. The next sample is
// accepted no earlier than the cycle after the load; in bypass no steps are run. The
// per-channel delay words are read and written through a small memory with one read
// and one write port, which sets the schedule's ends. A finished result waits in the
// output register while the next input is accepted. Coefficients and bypass must be
// written through the configuration port only while idle; the block does not enforce it.
module stereo_biquad_df2_filter import sbq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sbq_in_if.sink                i_in,
    sbq_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;
    t_sample out_sample;
    logic    out_clip;

    sbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sbq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_in.sample_in),
        .i_channel         (i_in.channel),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_filtered_sample (out_sample),
        .o_clipped         (out_clip)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.filtered_sample = out_sample;
    assign o_out.clipped         = out_clip;

endmodule

[rtl/sbq_ctrl.sv]
module sbq_ctrl import sbq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MS_A1W1;
        o_cmd.acc_op   = ACC_HOLD;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_status.bypass ? S_Y : S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_word = 1'b0;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.ld_w1   = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_word = 1'b1;
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.ld_w2   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_A1W1;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_A2W2;
                n_state = S_M3;
            end
            S_M3: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_B1W1;
                n_state = S_W;
            end
            S_W: begin
                o_cmd.fin_w   = 1'b1;
                o_cmd.acc_op  = ACC_LOAD_P;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_B2W2;
                n_state = S_M4;
            end
            S_M4: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_B0W;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_word = 1'b1;
                n_state = S_M5;
            end
            S_M5: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_word = 1'b0;
                n_state = S_Y;
            end
            S_Y: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // filter path takes a fixed schedule to the result stage
    a_filter_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_status.bypass |-> ##9 (r_state == S_Y))
        else $error("filter schedule broken");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_vld && (r_state == S_IDLE))
        else $error("result load did not raise valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |-> !o_cmd.load_out)
        else $error("pending result overwritten");

endmodule

[rtl/sbq_dp.sv]
module sbq_dp import sbq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_sample               i_sample,
    input  logic                  i_channel,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output t_sample               o_filtered_sample,
    output logic                  o_clipped
);

    t_sample r_b0, r_b1, r_b2, r_a1, r_a2;
    logic    r_bypass;

    t_sample r_x;
    logic    r_ch;
    logic    r_byp;
    logic    r_clip;
    t_word   r_w1, r_w2, r_w;
    t_word   r_rdata;
    t_prod   r_prod;
    t_acc    r_acc;
    t_sample r_out_sample;
    logic    r_out_clip;

    t_word   r_mem [4];
    logic    [3:0] r_vld;

    t_sample coef;
    t_word   oper;
    t_acc    rnd;
    t_q      q;
    logic    ovf32, ovf24;
    t_word   w_sat;
    t_sample y_sat;
    logic [1:0] rd_addr, wr_addr;
    t_word   wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= '0;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:     r_b0     <= i_cfg_data;
                REG_B1:     r_b1     <= i_cfg_data;
                REG_B2:     r_b2     <= i_cfg_data;
                REG_A1:     r_a1     <= i_cfg_data;
                REG_A2:     r_a2     <= i_cfg_data;
                REG_BYPASS: r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_status.bypass = r_bypass;

    // delay store: valid bits stand in for the cleared state
    assign rd_addr = {r_ch, i_cmd.rd_word};
    assign wr_addr = {r_ch, i_cmd.wr_word};
    assign wr_data = i_cmd.wr_word ? r_w1 : r_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_vld[rd_addr] ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MS_A1W1: begin coef = r_a1; oper = r_w1; end
            MS_A2W2: begin coef = r_a2; oper = r_w2; end
            MS_B1W1: begin coef = r_b1; oper = r_w1; end
            MS_B2W2: begin coef = r_b2; oper = r_w2; end
            MS_B0W:  begin coef = r_b0; oper = r_w;  end
            default: begin coef = r_b0; oper = r_w;  end
        endcase
    end

    // round half up, dropping 22 fraction bits, then saturate
    assign rnd   = r_acc + ROUND_HALF;
    assign q     = rnd[ACC_W-1:FRAC_SHIFT];
    assign ovf32 = (q[Q_W-1:WORD_W-1] != {(Q_W-WORD_W+1){q[WORD_W-1]}});
    assign ovf24 = (q[Q_W-1:SAMPLE_W-1] != {(Q_W-SAMPLE_W+1){q[SAMPLE_W-1]}});
    assign w_sat = ovf32 ? (q[Q_W-1] ? WORD_MIN : WORD_MAX) : q[WORD_W-1:0];
    assign y_sat = ovf24 ? (q[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX) : q[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= i_sample;
            r_ch   <= i_channel;
            r_byp  <= r_bypass;
            r_clip <= 1'b0;
            r_acc  <= t_acc'(i_sample) <<< FRAC_SHIFT;
        end else begin
            case (i_cmd.acc_op)
                ACC_SUB:    r_acc <= r_acc - t_acc'(r_prod);
                ACC_ADD:    r_acc <= r_acc + t_acc'(r_prod);
                ACC_LOAD_P: r_acc <= t_acc'(r_prod);
                default:    r_acc <= r_acc;
            endcase
        end
        if (i_cmd.ld_w1) begin
            r_w1 <= r_rdata;
        end
        if (i_cmd.ld_w2) begin
            r_w2 <= r_rdata;
        end
        if (i_cmd.mul_en) begin
            r_prod <= t_prod'(coef) * t_prod'(oper);
        end
        if (i_cmd.fin_w) begin
            r_w    <= w_sat;
            r_clip <= r_clip | ovf32;
        end
        if (i_cmd.load_out) begin
            r_out_sample <= r_byp ? r_x : y_sat;
            r_out_clip   <= r_byp ? 1'b0 : (r_clip | ovf24);
        end
    end

    assign o_filtered_sample = r_out_sample;
    assign o_clipped         = r_out_clip;

    a_bypass_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !r_byp)
        else $error("delay word written in bypass");

    a_bypass_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_byp |=> (o_filtered_sample == $past(r_x)) && !o_clipped)
        else $error("bypass result differs from input");

endmodule

[verif/tb_top.sv]
module tb_top import sbq_pkg::*; ();

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 30;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD   = 80;

    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    localparam t_sample COEF_ONE  = 24'sh400000;
    localparam t_sample COEF_HALF = 24'sh200000;
    localparam longint  HALF_LSB  = 64'sd1 <<< (FRAC_SHIFT - 1);

    typedef struct packed {
        t_sample sample;
        logic    clip;
    } t_filt_out;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sbq_in_if  in_if ();
    sbq_out_if out_if ();

    stereo_biquad_df2_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // filter model state
    t_sample gain_b0 = '0;
    t_sample gain_b1 = '0;
    t_sample gain_b2 = '0;
    t_sample gain_a1 = '0;
    t_sample gain_a2 = '0;
    logic    filt_bypass = 1'b1;
    t_word   delay_line [4] = '{default: '0};

    t_filt_out expected_q [$];
    int        err_count    = 0;
    int        cycle_count  = 0;
    int        hold_request = 0;
    logic      src_idle_en  = 1'b1;
    logic      sink_idle_en = 1'b1;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_filt_out biquad_predict(input t_sample x, input logic ch);
        t_filt_out  r;
        longint     w1;
        longint     w2;
        longint     acc;
        longint     w;
        longint     y;
        logic       clip;
        logic [1:0] base_w1;
        logic [1:0] base_w2;
        base_w1 = {ch, 1'b0};
        base_w2 = {ch, 1'b1};
        if (filt_bypass) begin
            r.sample = x;
            r.clip   = 1'b0;
            return r;
        end
        clip = 1'b0;
        w1   = longint'(delay_line[base_w1]);
        w2   = longint'(delay_line[base_w2]);
        acc  = (longint'(x) <<< FRAC_SHIFT) - longint'(gain_a1) * w1
               - longint'(gain_a2) * w2;
        w = (acc + HALF_LSB) >>> FRAC_SHIFT;
        if (w > longint'(WORD_MAX)) begin
            w    = longint'(WORD_MAX);
            clip = 1'b1;
        end else if (w < longint'(WORD_MIN)) begin
            w    = longint'(WORD_MIN);
            clip = 1'b1;
        end
        acc = longint'(gain_b0) * w + longint'(gain_b1) * w1 + longint'(gain_b2) * w2;
        y   = (acc + HALF_LSB) >>> FRAC_SHIFT;
        if (y > longint'(SAMPLE_MAX)) begin
            y    = longint'(SAMPLE_MAX);
            clip = 1'b1;
        end else if (y < longint'(SAMPLE_MIN)) begin
            y    = longint'(SAMPLE_MIN);
            clip = 1'b1;
        end
        delay_line[base_w2] = delay_line[base_w1];
        delay_line[base_w1] = t_word'(w);
        r.sample = t_sample'(y);
        r.clip   = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            expected_q.push_back(biquad_predict(in_if.sample_in, in_if.channel));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_filt_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", int'(out_if.filtered_sample), 0);
            end else begin
                want = expected_q.pop_front();
                if (out_if.filtered_sample !== want.sample) begin
                    report_mismatch("filtered_sample", int'(out_if.filtered_sample),
                                    int'(want.sample));
                end
                if (out_if.clipped !== want.clip) begin
                    report_mismatch("clipped", int'(out_if.clipped), int'(want.clip));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side: random stalls per transaction, plus an occasional long hold
    initial begin : sink_proc
        int gap;
        out_if.ready = 1'b0;
        forever begin
            gap = sink_idle_en ? int'($urandom_range(0, 3)) : 0;
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic send_sample(input t_sample s, input logic ch);
        int gap;
        gap = src_idle_en ? int'($urandom_range(0, 3)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= s;
        in_if.channel   <= ch;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_B0:     gain_b0 = t_sample'(data);
            REG_B1:     gain_b1 = t_sample'(data);
            REG_B2:     gain_b2 = t_sample'(data);
            REG_A1:     gain_a1 = t_sample'(data);
            REG_A2:     gain_a2 = t_sample'(data);
            REG_BYPASS: filt_bypass = data[0];
            default: ;
        endcase
    endtask

    function automatic t_sample random_sample();
        if ($urandom_range(0, 3) == 0) begin
            return t_sample'(int'($urandom_range(0, 2000)) - 1000);
        end
        return t_sample'($urandom);
    endfunction

    task automatic test_bypass_passthrough();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(-1), 1'b1);
        pause_until_drained();
    endtask

    // unmapped indexes must be ignored; only bit 0 of the bypass data counts
    task automatic test_register_decode();
        write_reg(IDX_UNMAPPED_LO, 24'hFFFFFF);
        write_reg(IDX_UNMAPPED_HI, 24'h5A5A5A);
        write_reg(REG_BYPASS, 24'hFFFFFE);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_unity_gain();
        write_reg(REG_B0, COEF_ONE);
        write_reg(REG_B1, COEF_ONE);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(t_sample'(1), 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        pause_until_drained();
        // rounding of exact halves
        write_reg(REG_B0, COEF_HALF);
        write_reg(REG_B1, '0);
        send_sample(t_sample'(1), 1'b1);
        send_sample(t_sample'(-1), 1'b1);
        pause_until_drained();
    endtask

    task automatic test_coeff_extremes();
        write_reg(REG_B0, SAMPLE_MIN);
        write_reg(REG_B1, SAMPLE_MIN);
        write_reg(REG_B2, SAMPLE_MIN);
        write_reg(REG_A1, SAMPLE_MIN);
        write_reg(REG_A2, SAMPLE_MIN);
        repeat (8) send_sample(SAMPLE_MAX, 1'b1);
        pause_until_drained();
        write_reg(REG_B0, SAMPLE_MAX);
        write_reg(REG_B1, SAMPLE_MAX);
        write_reg(REG_B2, SAMPLE_MAX);
        write_reg(REG_A1, SAMPLE_MAX);
        write_reg(REG_A2, SAMPLE_MAX);
        repeat (5) send_sample(SAMPLE_MIN, 1'b0);
        pause_until_drained();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_B0, 24'sh0C0000);
        write_reg(REG_B1, 24'sh180000);
        write_reg(REG_B2, 24'sh0C0000);
        write_reg(REG_A1, 24'shA00000);
        write_reg(REG_A2, 24'sh1C0000);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        hold_request = LONG_HOLD;
        repeat (16) send_sample(random_sample(), 1'($urandom_range(0, 1)));
        pause_until_drained();
        src_idle_en = 1'b1;
        repeat (8) send_sample(random_sample(), 1'($urandom_range(0, 1)));
        pause_until_drained();
    endtask

    task automatic test_random_phases();
        int               lim;
        int               a2;
        logic [CFG_DATA_W-1:0] data;
        for (int p = 0; p < PHASES; p++) begin
            if (p % 4 == 3) begin
                data    = CFG_DATA_W'($urandom);
                data[0] = 1'b1;
                write_reg(REG_BYPASS, data);
            end else begin
                if (p % 4 == 1) begin
                    write_reg(REG_B0, CFG_DATA_W'($urandom));
                    write_reg(REG_B1, CFG_DATA_W'($urandom));
                    write_reg(REG_B2, CFG_DATA_W'($urandom));
                    write_reg(REG_A1, CFG_DATA_W'($urandom));
                    write_reg(REG_A2, CFG_DATA_W'($urandom));
                end else begin
                    // stable pole pair: |a2| < 1, |a1| < 1 + a2
                    a2  = int'($urandom_range(0, 7969178)) - 3984589;
                    lim = ((4194304 + a2) * 19) / 20;
                    write_reg(REG_B0,
                              CFG_DATA_W'(int'($urandom_range(0, 4194304)) - 2097152));
                    write_reg(REG_B1,
                              CFG_DATA_W'(int'($urandom_range(0, 4194304)) - 2097152));
                    write_reg(REG_B2,
                              CFG_DATA_W'(int'($urandom_range(0, 4194304)) - 2097152));
                    write_reg(REG_A1, CFG_DATA_W'(int'($urandom_range(0, 2 * lim)) - lim));
                    write_reg(REG_A2, CFG_DATA_W'(a2));
                end
                data    = CFG_DATA_W'($urandom);
                data[0] = 1'b0;
                write_reg(REG_BYPASS, data);
            end
            src_idle_en  = (p % 3 != 2);
            sink_idle_en = (p % 3 != 1);
            repeat (PHASE_ITEMS) send_sample(random_sample(), 1'($urandom_range(0, 1)));
            pause_until_drained();
        end
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.sample_in = '0;
        in_if.channel   = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_bypass_passthrough();
        test_register_decode();
        test_unity_gain();
        test_coeff_extremes();
        test_output_backpressure();
        test_random_phases();
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
